// ===== rtl/wfpa_pkg.sv =====
// Package for the worst-fit partition allocator.
// Holds the transaction payload types, status and mode codes and default sizes.
// No dependencies.
package wfpa_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;
    localparam int IDX_FIELD_W    = 4;
    localparam int SIZE_FIELD_W   = 16;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_LOADED    = 2'd0,
        ST_ALLOCATED = 2'd1,
        ST_NO_SPACE  = 2'd2
    } t_status;

    typedef struct packed {
        logic                    mode;
        logic [IDX_FIELD_W-1:0]  block_index;
        logic [SIZE_FIELD_W-1:0] size;
    } t_in;

    typedef struct packed {
        t_status                 status;
        logic [IDX_FIELD_W-1:0]  chosen_block;
        logic [SIZE_FIELD_W-1:0] leftover;
    } t_out;

    typedef struct packed {
        logic load;
        logic clear;
    } t_tbl_ctl;

    typedef struct packed {
        logic clear;
        logic en;
    } t_cmp_ctl;

endpackage

// ===== rtl/worst_fit_partition_allocator_top.sv =====
// Worst-fit partition allocator, top level with the scan sequencer.
// A load transaction returns its result in the cycle after acceptance and busy stays low.
// An allocate transaction scans one block per cycle through the single table read port
// and the shared fit unit, then goes through S_LAST and S_COMMIT; busy is high until
// S_COMMIT ends. Results cannot be stalled by the receiver.
// Reset is synchronous: no block is free, block sizes are undefined until loaded.
module worst_fit_partition_allocator_top import wfpa_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_data,
    output logic o_strobe,
    output t_out o_result
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_addr, n_addr;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_cmp_en, n_cmp_en;
    logic [SIZE_WIDTH-1:0] r_req;
    logic                  r_strobe, n_strobe;
    t_out                  r_result, n_result;

    logic                  accept;
    logic [8:0]            idx_wide;
    logic [31:0]           size_wide;
    logic [SIZE_WIDTH-1:0] in_size;
    logic                  idx_ok;
    t_tbl_ctl              tbl_ctl;
    t_cmp_ctl              cmp_ctl;
    logic [SIZE_WIDTH-1:0] rd_size;
    logic                  rd_free;
    logic                  found;
    logic [IDX_W-1:0]      best;
    logic [SIZE_WIDTH-1:0] best_left;
    logic [8:0]            best_wide;
    logic [31:0]           left_wide;

    always_comb begin
        accept    = start && !busy;
        idx_wide  = 9'(i_data.block_index);
        size_wide = 32'(i_data.size);
        in_size   = size_wide[SIZE_WIDTH-1:0];
        idx_ok    = idx_wide < 9'(NUM_BLOCKS);
        best_wide = 9'(best);
        left_wide = 32'(best_left);

        tbl_ctl.load  = accept && (i_data.mode == MODE_LOAD) && idx_ok;
        tbl_ctl.clear = (r_state == S_COMMIT) && found;
        cmp_ctl.clear = accept && (i_data.mode == MODE_ALLOC);
        cmp_ctl.en    = r_cmp_en;
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_cmp_en = 1'b0;
        n_strobe = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_data.mode == MODE_LOAD) begin
                        n_strobe = 1'b1;
                        n_result = '{status: ST_LOADED, chosen_block: '0, leftover: '0};
                    end else begin
                        n_addr  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_cmp_en = 1'b1;
                n_addr   = r_addr + 1'b1;
                if (r_addr == IDX_W'(NUM_BLOCKS - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_strobe = 1'b1;
                if (found) begin
                    n_result = '{status: ST_ALLOCATED,
                                 chosen_block: best_wide[IDX_FIELD_W-1:0],
                                 leftover: left_wide[SIZE_FIELD_W-1:0]};
                end else begin
                    n_result = '{status: ST_NO_SPACE, chosen_block: '0, leftover: '0};
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmp_en <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_en <= n_cmp_en;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_cmp_idx <= r_addr;
        r_result  <= n_result;
        if (accept) begin
            r_req <= in_size;
        end
    end

    wfpa_table #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_WIDTH(SIZE_WIDTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tbl_ctl),
        .i_wr_addr (idx_wide[IDX_W-1:0]),
        .i_wr_size (in_size),
        .i_clr_addr(best),
        .i_rd_addr (r_addr),
        .o_rd_size (rd_size),
        .o_rd_free (rd_free)
    );

    wfpa_cmp #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_WIDTH(SIZE_WIDTH)
    ) u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cmp_ctl),
        .i_idx      (r_cmp_idx),
        .i_size     (rd_size),
        .i_free     (rd_free),
        .i_req      (r_req),
        .o_found    (found),
        .o_best     (best),
        .o_best_left(best_left)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/wfpa_table.sv =====
// Partition table: block size memory with a registered read port and free flags.
// Depends on wfpa_pkg for the control struct.
module wfpa_table import wfpa_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF,
    localparam int IDX_W     = $clog2(NUM_BLOCKS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tbl_ctl              i_ctl,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  logic [SIZE_WIDTH-1:0] i_wr_size,
    input  logic [IDX_W-1:0]      i_clr_addr,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output logic [SIZE_WIDTH-1:0] o_rd_size,
    output logic                  o_rd_free
);

    logic [SIZE_WIDTH-1:0] r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_free;
    logic [SIZE_WIDTH-1:0] r_rd_size;
    logic                  r_rd_free;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mem[i_wr_addr] <= i_wr_size;
        end
        r_rd_size <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= '0;
            r_rd_free <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_free[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.clear) begin
                r_free[i_clr_addr] <= 1'b0;
            end
            r_rd_free <= r_free[i_rd_addr];
        end
    end

    assign o_rd_size = r_rd_size;
    assign o_rd_free = r_rd_free;

endmodule

// ===== rtl/wfpa_cmp.sv =====
// Shared fit unit: subtracts the request from one block size per cycle and keeps
// the best candidate so far. Depends on wfpa_pkg for the control struct.
module wfpa_cmp import wfpa_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF,
    localparam int IDX_W     = $clog2(NUM_BLOCKS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmp_ctl              i_ctl,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [SIZE_WIDTH-1:0] i_size,
    input  logic                  i_free,
    input  logic [SIZE_WIDTH-1:0] i_req,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_best,
    output logic [SIZE_WIDTH-1:0] o_best_left
);

    logic                  r_found;
    logic [IDX_W-1:0]      r_best;
    logic [SIZE_WIDTH-1:0] r_best_left;
    logic [SIZE_WIDTH-1:0] left;
    logic                  fits;
    logic                  better;

    always_comb begin
        left   = i_size - i_req;
        fits   = i_free && (i_size >= i_req);
        better = fits && (!r_found || (left > r_best_left));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.en && better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && better) begin
            r_best      <= i_idx;
            r_best_left <= left;
        end
    end

    assign o_found     = r_found;
    assign o_best      = r_best;
    assign o_best_left = r_best_left;

endmodule
